>>> sv/frustum_box_cull_assert.svh
// Assertion macros for the checker file of the box culling block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum_box_cull: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum_box_cull: check failed");

`endif

>>> sv/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

    // Field and register widths.
    localparam int COORD_BITS   = 24;
    localparam int COORD_FRAC   = 8;
    localparam int MATRIX_BITS  = 16;
    localparam int ENTRY_STRIDE = 16;
    localparam int CFG_BITS     = 64;
    localparam int NUM_ROWS     = 4;
    localparam int CFG_IDX_BITS = $clog2(NUM_ROWS);
    localparam int NUM_PLANES   = 6;
    localparam int NUM_AXES     = 3;

    // Derived arithmetic widths: plane coefficients are sums of two entries,
    // products are exact, and the full plane sum needs two more bits.
    localparam int COEF_BITS = MATRIX_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + COORD_BITS;
    localparam int PSUM_BITS = PROD_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 2;

    // Stream word widths, rounded up to whole bytes.
    localparam int IN_FIELDS_BITS = 6 * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELDS_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW3 = CFG_IDX_BITS'(3);

    // Plane order.
    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    // Coefficient slot holding the plane offset.
    localparam int COEF_D = 3;

    // Identity matrix rows after reset.
    localparam logic [CFG_BITS-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [CFG_BITS-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [CFG_BITS-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [CFG_BITS-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    typedef logic [CFG_BITS-1:0]          row_t;
    typedef row_t [NUM_ROWS-1:0]          row_set_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef coef_t [3:0]                  plane_t;
    typedef plane_t [NUM_PLANES-1:0]      plane_set_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [PSUM_BITS-1:0]  psum_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;

    // One box as it enters the pipeline.
    typedef struct packed {
        coord_t max_z;
        coord_t max_y;
        coord_t max_x;
        coord_t min_z;
        coord_t min_y;
        coord_t min_x;
    } box_t;

    // Corner products, one per plane and axis.
    typedef struct packed {
        logic                                    box_empty;
        prod_t [NUM_PLANES-1:0][NUM_AXES-1:0]    prod;
    } prod_word_t;

    // Partial plane sums: x plus y, and z plus the scaled offset.
    typedef struct packed {
        logic                      box_empty;
        psum_t [NUM_PLANES-1:0]    sum_xy;
        psum_t [NUM_PLANES-1:0]    sum_zd;
    } sum_word_t;

    // Result word.
    typedef struct packed {
        logic box_empty;
        logic visible;
    } result_t;

endpackage

`default_nettype wire

>>> sv/fbc_cfg.sv
`default_nettype none

module fbc_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [fbc_pkg::CFG_BITS-1:0]     cfg_data,
    output fbc_pkg::plane_set_t                   planes
);
    import fbc_pkg::*;

    row_set_t   rows_reg;
    row_set_t   rows_next;
    plane_set_t planes_reg;

    // Extract one signed matrix entry and widen it to coefficient width.
    function automatic coef_t entry(input row_t row, input int col);
        coef_t e;
        e = COEF_BITS'(signed'(row[ENTRY_STRIDE*col +: MATRIX_BITS]));
        return e;
    endfunction

    // Form the six clip planes from the matrix rows.
    function automatic plane_set_t derive_planes(input row_set_t r);
        plane_set_t p;
        for (int j = 0; j < 4; j++)
        begin
            p[PL_LEFT][j]   = entry(r[3], j) + entry(r[0], j);
            p[PL_RIGHT][j]  = entry(r[3], j) - entry(r[0], j);
            p[PL_BOTTOM][j] = entry(r[3], j) + entry(r[1], j);
            p[PL_TOP][j]    = entry(r[3], j) - entry(r[1], j);
            p[PL_NEAR][j]   = entry(r[2], j);
            p[PL_FAR][j]    = entry(r[3], j) - entry(r[2], j);
        end
        return p;
    endfunction

    // Register write decode.
    always_comb
    begin
        rows_next = rows_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW0: rows_next[0] = cfg_data;
                REG_ROW1: rows_next[1] = cfg_data;
                REG_ROW2: rows_next[2] = cfg_data;
                REG_ROW3: rows_next[3] = cfg_data;
                default:  rows_next = rows_reg;
            endcase
        end
    end

    // Matrix rows, and the planes derived from them in the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= {ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};
            planes_reg <= derive_planes({ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET});
        end
        else
        begin
            rows_reg   <= rows_next;
            planes_reg <= derive_planes(rows_reg);
        end
    end

    assign planes = planes_reg;

endmodule

`default_nettype wire

>>> sv/fbc_mul.sv
`default_nettype none

module fbc_mul (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fbc_pkg::plane_set_t planes,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fbc_pkg::box_t in_box,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fbc_pkg::prod_word_t out_word
);
    import fbc_pkg::*;

    coord_t [NUM_AXES-1:0] lo;
    coord_t [NUM_AXES-1:0] hi;
    prod_word_t            word_next;
    prod_word_t            word_reg;
    logic                  valid_reg;

    assign lo = {in_box.min_z, in_box.min_y, in_box.min_x};
    assign hi = {in_box.max_z, in_box.max_y, in_box.max_x};

    // Empty test, then pick the far corner per plane and axis and multiply.
    always_comb
    begin
        word_next.box_empty = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if ($signed(lo[k]) > $signed(hi[k]))
            begin
                word_next.box_empty = 1'b1;
            end
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                word_next.prod[p][k] = $signed(planes[p][k])
                    * $signed(planes[p][k][COEF_BITS-1] ? lo[k] : hi[k]);
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

>>> sv/fbc_reduce.sv
`default_nettype none

module fbc_reduce (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fbc_pkg::plane_set_t planes,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fbc_pkg::prod_word_t in_word,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fbc_pkg::result_t    out_result
);
    import fbc_pkg::*;

    sum_word_t sum_next;
    sum_word_t sum_reg;
    logic      sum_valid_reg;
    logic      sum_ready;
    result_t   res_next;
    result_t   res_reg;
    logic      res_valid_reg;
    acc_t      total;
    logic      any_fail;

    // First adder level: x plus y, and z plus the offset scaled to the
    // coordinate fraction.
    always_comb
    begin
        sum_next.box_empty = in_word.box_empty;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            sum_next.sum_xy[p] = PSUM_BITS'($signed(in_word.prod[p][0]))
                               + PSUM_BITS'($signed(in_word.prod[p][1]));
            sum_next.sum_zd[p] = PSUM_BITS'($signed(in_word.prod[p][2]))
                               + PSUM_BITS'(signed'({planes[p][COEF_D],
                                                     {COORD_FRAC{1'b0}}}));
        end
    end

    // Second adder level: a negative plane sum rejects the box.
    always_comb
    begin
        total    = '0;
        any_fail = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            total = ACC_BITS'($signed(sum_reg.sum_xy[p]))
                  + ACC_BITS'($signed(sum_reg.sum_zd[p]));
            if (total[ACC_BITS-1])
            begin
                any_fail = 1'b1;
            end
        end
        res_next.box_empty = sum_reg.box_empty;
        res_next.visible   = !sum_reg.box_empty && !any_fail;
    end

    assign sum_ready = !res_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && sum_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

`default_nettype wire

>>> sv/frustum_box_cull.sv
// Frustum culling for axis-aligned boxes. Write the four rows of the
// view-projection matrix (signed Q4.12 entries, column 0 in the low bits)
// through the configuration port while no box is in flight; a new matrix
// applies to boxes accepted from the first clock edge after the write. Each
// input word carries one box in signed Q16.8 coordinates, and each output
// word reports visible and box_empty for that box, in order. The block takes
// one box per clock cycle while the output side does not stall; an accepted
// box is registered in turn by the input register, the multiplier stage and
// the two adder stages before its result reaches the output. A stalled output
// back-pressures the input only once all four stages hold a word.
`default_nettype none

module frustum_box_cull (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [fbc_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z from the lowest bit up
    input  wire logic [fbc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // visible, box_empty from the lowest bit up, zero padded
    output logic [fbc_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata
);
    import fbc_pkg::*;

    plane_set_t planes;
    box_t       box_next;
    box_t       box_reg;
    logic       box_valid_reg;
    logic       mul_ready;
    logic       mul_valid;
    prod_word_t mul_word;
    logic       red_ready;
    result_t    result;

    // Matrix registers and plane coefficients.
    fbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // Unpack the input word.
    assign box_next.min_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign box_next.min_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign box_next.min_z = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign box_next.max_x = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    assign box_next.max_y = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    assign box_next.max_z = s_axis_tdata[5*COORD_BITS +: COORD_BITS];

    // Input register stage.
    assign s_axis_tready = !box_valid_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            box_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            box_reg <= box_next;
        end
    end

    // Corner selection and products.
    fbc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .planes    (planes),
        .in_valid  (box_valid_reg),
        .in_ready  (mul_ready),
        .in_box    (box_reg),
        .out_valid (mul_valid),
        .out_ready (red_ready),
        .out_word  (mul_word)
    );

    // Plane sums, sign test and output register.
    fbc_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .planes     (planes),
        .in_valid   (mul_valid),
        .in_ready   (red_ready),
        .in_word    (mul_word),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_BITS-2){1'b0}}, result.box_empty, result.visible};

endmodule

`default_nettype wire

>>> sv/fbc_checker.sv
`default_nettype none
`include "frustum_box_cull_assert.svh"

module fbc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [fbc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    // A stalled result word stays put until it is taken.
    `FBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // With the output free to move, every stage can advance and the input is ready.
    `FBC_ASSERT_IMPL(a_in_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    // An empty box is never reported visible.
    `FBC_ASSERT_IMPL(a_empty_hidden, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0])

    // Padding bits of the result word stay zero.
    `FBC_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[fbc_pkg::OUT_TDATA_BITS-1:2] == '0)

    // An input word offered while no result waits on the output finds the input ready.
    `FBC_ASSERT_IMPL(a_accept_live, s_axis_tvalid && !m_axis_tvalid, s_axis_tready)

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    import fbc_pkg::*;

    localparam coord_t CMIN = coord_t'(-8388608);
    localparam coord_t CMAX = coord_t'(8388607);
    localparam int     ONE  = 256;   // 1.0 in Q16.8

    // Keeps its own copy of the matrix rows, predicts the verdict for every
    // accepted box and compares each output word against the oldest one.
    class cull_scoreboard;
        row_t    rows[NUM_ROWS];
        result_t expected_verdicts[$];
        int      errors;
        int      n_boxes;
        int      n_visible;
        int      n_culled;
        int      n_empty;

        function new();
            rows[REG_ROW0] = ROW0_RESET;
            rows[REG_ROW1] = ROW1_RESET;
            rows[REG_ROW2] = ROW2_RESET;
            rows[REG_ROW3] = ROW3_RESET;
            errors    = 0;
            n_boxes   = 0;
            n_visible = 0;
            n_culled  = 0;
            n_empty   = 0;
        endfunction

        // Six planes from row sums and differences, the near plane from row 2 alone;
        // each plane is tested at the corner farthest along its normal, with the
        // offset scaled up to the coordinate fraction.
        function result_t predict_verdict(box_t b);
            longint  lo[NUM_AXES];
            longint  hi[NUM_AXES];
            longint  ent[NUM_ROWS][4];
            longint  pl[NUM_PLANES][4];
            longint  acc;
            result_t v;
            v = '0;
            lo[0] = $signed(b.min_x);
            lo[1] = $signed(b.min_y);
            lo[2] = $signed(b.min_z);
            hi[0] = $signed(b.max_x);
            hi[1] = $signed(b.max_y);
            hi[2] = $signed(b.max_z);
            for (int k = 0; k < NUM_AXES; k++)
            begin
                if (lo[k] > hi[k])
                    v.box_empty = 1'b1;
            end
            if (v.box_empty)
                return v;
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                for (int j = 0; j < 4; j++)
                    ent[i][j] = $signed(rows[i][ENTRY_STRIDE*j +: MATRIX_BITS]);
            end
            for (int j = 0; j < 4; j++)
            begin
                pl[PL_LEFT][j]   = ent[3][j] + ent[0][j];
                pl[PL_RIGHT][j]  = ent[3][j] - ent[0][j];
                pl[PL_BOTTOM][j] = ent[3][j] + ent[1][j];
                pl[PL_TOP][j]    = ent[3][j] - ent[1][j];
                pl[PL_NEAR][j]   = ent[2][j];
                pl[PL_FAR][j]    = ent[3][j] - ent[2][j];
            end
            v.visible = 1'b1;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                acc = pl[p][COEF_D] * (longint'(1) << COORD_FRAC);
                for (int k = 0; k < NUM_AXES; k++)
                    acc += pl[p][k] * ((pl[p][k] >= 0) ? hi[k] : lo[k]);
                if (acc < 0)
                    v.visible = 1'b0;
            end
            return v;
        endfunction

        function void note_box(box_t b);
            expected_verdicts.push_back(predict_verdict(b));
            n_boxes++;
        endfunction

        function void check_result(logic [OUT_TDATA_BITS-1:0] word);
            result_t got;
            result_t want;
            got = word[1:0];
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: output word %h arrived with no box pending", word);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.visible !== want.visible || got.box_empty !== want.box_empty)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: visible exp %b got %b, box_empty exp %b got %b",
                             want.visible, got.visible, want.box_empty, got.box_empty);
            end
            if (want.box_empty)
                n_empty++;
            else if (want.visible)
                n_visible++;
            else
                n_culled++;
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    bit             free_run = 1'b0;
    int             n_settings = 1;
    cull_scoreboard sb = new();

    frustum_box_cull u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Watch both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_box(box_t'(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Output side: random stall bursts, runs of readiness, none at the end.
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            if (!free_run && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b0;
                end
            end
            else
            begin
                n = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 20);
                repeat (n)
                begin
                    @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic row_t pack4(int e0, int e1, int e2, int e3);
        return {16'(e3), 16'(e2), 16'(e1), 16'(e0)};
    endfunction

    function automatic coord_t rand_coord(int bits);
        return coord_t'(int'($urandom_range(0, (1 << (bits + 1)) - 1)) - (1 << bits));
    endfunction

    function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t b;
        b.min_x = coord_t'(lx);
        b.min_y = coord_t'(ly);
        b.min_z = coord_t'(lz);
        b.max_x = coord_t'(hx);
        b.max_y = coord_t'(hy);
        b.max_z = coord_t'(hz);
        return b;
    endfunction

    // Mostly well-formed boxes at several scales, plus points, empty boxes
    // and raw full-range words.
    function automatic box_t make_box();
        int     kind;
        int     bits;
        int     ax;
        coord_t u;
        coord_t w;
        coord_t lo[NUM_AXES];
        coord_t hi[NUM_AXES];
        box_t   b;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: bits = 9;
            1: bits = 12;
            2: bits = 16;
            default: bits = 23;
        endcase
        if (kind >= 8 && kind < 20)
            bits = 23;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            u = rand_coord(bits);
            w = rand_coord(bits);
            if (kind >= 8 && kind < 20)
            begin
                lo[k] = u;
                hi[k] = w;
            end
            else if (kind >= 20 && kind < 30)
            begin
                lo[k] = u;
                hi[k] = u;
            end
            else
            begin
                lo[k] = (u < w) ? u : w;
                hi[k] = (u < w) ? w : u;
            end
        end
        // Force an empty box on one axis.
        if (kind < 8)
        begin
            ax = $urandom_range(0, 2);
            u = lo[ax];
            lo[ax] = hi[ax];
            hi[ax] = u;
            if (lo[ax] == hi[ax])
            begin
                if (hi[ax] == CMIN)
                    lo[ax] = hi[ax] + 1;
                else
                    hi[ax] = lo[ax] - 1;
            end
        end
        b.min_x = lo[0];
        b.min_y = lo[1];
        b.min_z = lo[2];
        b.max_x = hi[0];
        b.max_y = hi[1];
        b.max_z = hi[2];
        return b;
    endfunction

    task automatic sender_idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic send_box(box_t b);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Hold the input until every pending verdict has come back.
    task automatic wait_drained();
        sender_idle(1);
        while (sb.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all four rows while the block is idle.
    task automatic load_matrix(row_t r0, row_t r1, row_t r2, row_t r3);
        row_t m[NUM_ROWS];
        m[REG_ROW0] = r0;
        m[REG_ROW1] = r1;
        m[REG_ROW2] = r2;
        m[REG_ROW3] = r3;
        wait_drained();
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_BITS'(i);
            cfg_data  <= m[i];
            @(posedge clk);
            sb.rows[i] = m[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(int n, int gap_odds);
        for (int i = 0; i < n; i++)
        begin
            if (gap_odds != 0 && !free_run && $urandom_range(1, gap_odds) == 1)
                sender_idle($urandom_range(1, 10));
            send_box(make_box());
        end
    endtask

    // Boxes at the field extremes and on each identity-matrix plane.
    task automatic run_directed();
        send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, -1, 0, 0, -1));
        send_box(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_box(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_box(mk_box(1, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 1, 0, 0, 0, 0));
        send_box(mk_box(0, 0, 1, 0, 0, 0));
        send_box(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_box(mk_box(-1000, 0, 0, -ONE - 1, 0, 0));
        send_box(mk_box(-1000, 0, 0, -ONE, 0, 0));
        send_box(mk_box(ONE + 1, 0, 0, 1000, 0, 0));
        send_box(mk_box(ONE, 0, 0, 1000, 0, 0));
        send_box(mk_box(0, -1000, 0, 0, -ONE - 1, 0));
        send_box(mk_box(0, ONE + 1, 0, 0, 1000, 0));
        send_box(mk_box(0, 0, ONE + 1, 0, 0, 1000));
        send_box(mk_box(0, 0, -5, 0, 0, 0));
        send_box(mk_box(ONE, ONE, ONE, ONE, ONE, ONE));
        send_box(mk_box(-ONE, -ONE, 0, -ONE, -ONE, 0));
        send_box(mk_box(CMIN, CMIN, CMIN, CMIN + 1, CMIN + 1, CMIN + 1));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset matrix first, then a series of matrix settings.
        run_directed();
        run_random(120, 4);
        load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_random(150, 3);
        load_matrix(pack4(4096, 0, 0, 0), pack4(0, 4096, 0, 0),
                    pack4(0, 0, -4096, -512), pack4(0, 0, -4096, 0));
        run_random(160, 4);
        load_matrix(pack4(32767, 32767, 32767, 32767), pack4(32767, 32767, 32767, 32767),
                    pack4(32767, 32767, 32767, 32767), pack4(32767, 32767, 32767, 32767));
        run_random(100, 0);
        load_matrix(pack4(-32768, -32768, -32768, -32768),
                    pack4(-32768, -32768, -32768, -32768),
                    pack4(-32768, -32768, -32768, -32768),
                    pack4(-32768, -32768, -32768, -32768));
        run_random(100, 6);
        // Zero normals: only the offset decides.
        load_matrix('0, '0, '0, '0);
        run_random(60, 3);
        load_matrix('0, '0, '0, pack4(0, 0, 0, -4096));
        run_random(60, 3);
        load_matrix('1, '1, '1, '1);
        run_random(80, 3);
        load_matrix(pack4($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192),
                    pack4($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192),
                    pack4($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                          $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192),
                    pack4($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(4096, 16383)));
        run_random(150, 4);
        load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_random(100, 4);
        wait_drained();
        run_random(100, 4);

        // Last stretch at full rate on both sides.
        free_run = 1'b1;
        load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, ROW3_RESET);
        run_random(150, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Checked %0d boxes over %0d matrix settings.", sb.n_boxes, n_settings);
        $display("Verdicts: %0d visible, %0d culled, %0d empty; %0d mismatches.",
                 sb.n_visible, sb.n_culled, sb.n_empty, sb.errors);
        if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
